// ----- hdl/bfrb_pkg.sv -----
// Shared types, codes and constants of the bus frame request builder.
package bfrb_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int IDX_W           = 10;
    localparam int BATCH_BYTES     = 3;

    localparam logic [IDX_W-1:0] MAX_FRAME_IDX = IDX_W'(MAX_FRAME_BYTES);

    localparam logic [1:0] MODE_BEGIN  = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_NO_FRAME = 2'd2;

    localparam logic [7:0] CFG_START_OPCODE    = 8'd0;
    localparam logic [7:0] CFG_CONTINUE_OPCODE = 8'd1;
    localparam logic [7:0] CFG_OFFSET_OPCODE   = 8'd2;
    localparam logic [7:0] CFG_END_OPCODE      = 8'd3;

    localparam logic [7:0] LOW6_MASK  = 8'h3F;
    localparam logic [7:0] HIGH3_MASK = 8'h07;

    typedef struct packed {
        logic [7:0] start_opcode;
        logic [7:0] continue_opcode;
        logic [7:0] offset_opcode;
        logic [7:0] end_opcode;
    } t_cfg;

    typedef struct packed {
        logic             frame_open;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       running_sum;
    } t_state;

    // The result bytes caused by one input item, emitted from entry 0 upward.
    typedef struct packed {
        logic [BATCH_BYTES-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic [1:0]                  err;
    } t_batch;

endpackage

// ----- hdl/bfrb_build.sv -----
// Combinational request builder: one input item to its batch of request bytes.
module bfrb_build (
    input  bfrb_pkg::t_cfg   i_cfg,
    input  bfrb_pkg::t_state i_state,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_ctrl_byte,
    input  logic [7:0]       i_data_byte,
    output bfrb_pkg::t_batch o_batch,
    output bfrb_pkg::t_state o_next
);
    import bfrb_pkg::*;

    logic [IDX_W-1:0] idx;
    logic [7:0]       offset_byte;
    logic [7:0]       continue_byte;

    assign idx           = i_state.byte_index;
    assign offset_byte   = i_cfg.offset_opcode | ({5'd0, idx[8:6]} & HIGH3_MASK);
    assign continue_byte = i_cfg.continue_opcode | ({2'd0, idx[5:0]} & LOW6_MASK);

    always_comb begin
        o_batch = '0;
        o_next  = i_state;
        unique case (i_mode)
            MODE_BEGIN: begin
                o_batch.bytes[0]   = i_cfg.start_opcode;
                o_batch.bytes[1]   = i_ctrl_byte;
                o_batch.count      = 2'd2;
                o_next.frame_open  = 1'b1;
                o_next.byte_index  = '0;
                o_next.running_sum = '0;
            end
            MODE_DATA: begin
                if (!i_state.frame_open) begin
                    o_batch.count = 2'd1;
                    o_batch.err   = ERR_NO_FRAME;
                end else if (idx >= MAX_FRAME_IDX) begin
                    o_batch.count = 2'd1;
                    o_batch.err   = ERR_TOO_LONG;
                end else begin
                    // At each 64-byte boundary the offset opcode goes first.
                    if (idx[5:0] == 6'd0) begin
                        o_batch.bytes[0] = offset_byte;
                        o_batch.bytes[1] = continue_byte;
                        o_batch.bytes[2] = i_data_byte;
                        o_batch.count    = 2'd3;
                    end else begin
                        o_batch.bytes[0] = continue_byte;
                        o_batch.bytes[1] = i_data_byte;
                        o_batch.count    = 2'd2;
                    end
                    o_next.byte_index  = idx + IDX_W'(1);
                    o_next.running_sum = i_state.running_sum + i_data_byte;
                end
            end
            MODE_FINISH: begin
                if (!i_state.frame_open) begin
                    o_batch.count = 2'd1;
                    o_batch.err   = ERR_NO_FRAME;
                end else begin
                    o_batch.bytes[0]  = i_cfg.end_opcode | ({2'd0, idx[5:0]} & LOW6_MASK);
                    o_batch.bytes[1]  = i_state.running_sum;
                    o_batch.count     = 2'd2;
                    o_next.frame_open = 1'b0;
                end
            end
            default: begin
                // The unused mode causes no result and leaves the state alone.
            end
        endcase
    end

endmodule

// ----- hdl/bus_frame_request_builder_core.sv -----
// Top level of the bus frame request builder: ports, state, config and output buffer.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s (item) | in        | tvalid / tready    | tdata: ctrl_byte, data_byte; tuser: mode
//  m (req)  | out       | tvalid / tready    | tdata: out_byte; tlast: run_last;
//           |           |                    | tuser: error_code
//  cfg      | in        | valid / ready      | index, data (opcode registers 0..3)
//
// An item is turned into its request bytes (none for the unused mode) in the cycle it is
// accepted; the frame state is updated at the same edge. The batch is registered into the
// current slot when that is free, else into the pending slot, and is offered from there.
// The bytes leave one per cycle through the output port while the receiver is ready, so
// an item occupies the output for one transfer per result byte: 1 for an error, 2 for
// begin, finish and most data items, and 3 for a data item at a 64-byte boundary.
// A two-batch buffer lets the next item be accepted while the current batch drains.
// Reset clears the frame state and the buffer and restores the opcode registers.
// A stalled output holds its byte; the input stalls only when both batches are full.
module bus_frame_request_builder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] ctrl_byte, [15:8] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser,   // [1:0] error_code
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import bfrb_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_batch     n_batch;
    t_batch     r_cur;
    t_batch     r_pend;
    logic       r_cur_v;
    logic       r_pend_v;
    logic [1:0] r_pos;

    logic in_fire;
    logic new_v;
    logic out_fire;
    logic cur_last;
    logic cur_done;
    logic cur_free;

    bfrb_build u_build (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_mode      (i_s_tuser),
        .i_ctrl_byte (i_s_tdata[7:0]),
        .i_data_byte (i_s_tdata[15:8]),
        .o_batch     (n_batch),
        .o_next      (n_state)
    );

    assign cur_last   = (r_pos == (r_cur.count - 2'd1));
    assign out_fire   = r_cur_v && i_m_tready;
    assign cur_done   = out_fire && cur_last;
    assign cur_free   = !r_cur_v || cur_done;
    assign o_s_tready = !r_pend_v || cur_done;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign new_v      = in_fire && (n_batch.count != 2'd0);

    assign o_m_tvalid = r_cur_v;
    assign o_m_tdata  = r_cur.bytes[r_pos];
    assign o_m_tlast  = cur_last;
    assign o_m_tuser  = r_cur.err;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_opcode    <= 8'h80;
            r_cfg.continue_opcode <= 8'h80;
            r_cfg.offset_opcode   <= 8'h08;
            r_cfg.end_opcode      <= 8'h40;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_OPCODE:    r_cfg.start_opcode    <= i_cfg_data;
                CFG_CONTINUE_OPCODE: r_cfg.continue_opcode <= i_cfg_data;
                CFG_OFFSET_OPCODE:   r_cfg.offset_opcode   <= i_cfg_data;
                CFG_END_OPCODE:      r_cfg.end_opcode      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Buffer control: the current batch drains byte by byte, the pending one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v  <= 1'b0;
            r_pend_v <= 1'b0;
            r_pos    <= '0;
        end else if (cur_free) begin
            r_pos <= '0;
            if (r_pend_v) begin
                r_cur_v  <= 1'b1;
                r_pend_v <= new_v;
            end else begin
                r_cur_v  <= new_v;
                r_pend_v <= 1'b0;
            end
        end else begin
            if (out_fire) begin
                r_pos <= r_pos + 2'd1;
            end
            if (new_v) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cur_free) begin
            if (r_pend_v) begin
                r_cur <= r_pend;
                if (new_v) begin
                    r_pend <= n_batch;
                end
            end else if (new_v) begin
                r_cur <= n_batch;
            end
        end else if (new_v) begin
            r_pend <= n_batch;
        end
    end

endmodule

// ----- hdl/bfrb_checker.sv -----
// Port-level checker for the bus frame request builder core, with its bind.
module bfrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [1:0] o_m_tuser
);
    import bfrb_pkg::*;

    // An error result stands alone, so it always ends its run.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ERR_NONE)) |-> o_m_tlast)
        else $error("error transfer without tlast");

    a_err_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ERR_NONE)) |-> (o_m_tdata == 8'd0))
        else $error("error transfer with nonzero byte");

    a_err_code_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == ERR_NONE) || (o_m_tuser == ERR_TOO_LONG)
                        || (o_m_tuser == ERR_NO_FRAME)))
        else $error("undefined error code on output");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind bus_frame_request_builder_core bfrb_checker u_bfrb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the bus frame request builder core.
`timescale 1ns / 100ps

module tb;
    import bfrb_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] ctrl;
        logic [7:0] data;
    } t_frame_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic [1:0] error_code;
    } t_req_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;   // [7:0] ctrl_byte, [15:8] data_byte
    logic [1:0]  i_s_tuser   = '0;   // [1:0] mode
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;          // [7:0] out_byte
    logic        o_m_tlast;
    logic [1:0]  o_m_tuser;          // [1:0] error_code
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;

    t_frame_item item_q[$];
    t_req_byte   req_byte_q[$];

    // Shadow copy of the frame state and the opcode registers.
    logic             frame_open  = 1'b0;
    logic [IDX_W-1:0] frame_index = '0;
    logic [7:0]       frame_sum   = '0;
    t_cfg             opcodes     = '{start_opcode: 8'h80, continue_opcode: 8'h80,
                                      offset_opcode: 8'h08, end_opcode: 8'h40};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    bus_frame_request_builder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void queue_req_byte(input logic [7:0] b, input logic last,
                                           input logic [1:0] err);
        req_byte_q.push_back('{out_byte: b, run_last: last, error_code: err});
    endfunction

    // Works out the request bytes of one accepted item and advances the frame state.
    function automatic void build_request(input t_frame_item it);
        case (it.mode)
            MODE_BEGIN: begin
                queue_req_byte(opcodes.start_opcode, 1'b0, ERR_NONE);
                queue_req_byte(it.ctrl, 1'b1, ERR_NONE);
                frame_open  = 1'b1;
                frame_index = '0;
                frame_sum   = '0;
            end
            MODE_DATA: begin
                if (!frame_open) begin
                    queue_req_byte(8'h00, 1'b1, ERR_NO_FRAME);
                end else if (frame_index >= MAX_FRAME_IDX) begin
                    // The byte is dropped and the frame stays open.
                    queue_req_byte(8'h00, 1'b1, ERR_TOO_LONG);
                end else begin
                    if ((8'(frame_index) & LOW6_MASK) == 8'h00)
                        queue_req_byte(opcodes.offset_opcode |
                                       (8'(frame_index >> 6) & HIGH3_MASK), 1'b0, ERR_NONE);
                    queue_req_byte(opcodes.continue_opcode | (8'(frame_index) & LOW6_MASK),
                                   1'b0, ERR_NONE);
                    queue_req_byte(it.data, 1'b1, ERR_NONE);
                    frame_index = frame_index + 1'b1;
                    frame_sum   = frame_sum + it.data;
                end
            end
            MODE_FINISH: begin
                if (!frame_open) begin
                    queue_req_byte(8'h00, 1'b1, ERR_NO_FRAME);
                end else begin
                    queue_req_byte(opcodes.end_opcode | (8'(frame_index) & LOW6_MASK),
                                   1'b0, ERR_NONE);
                    queue_req_byte(frame_sum, 1'b1, ERR_NONE);
                    frame_open = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        t_frame_item it;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = item_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= it.mode;
                i_s_tdata  <= {it.data, it.ctrl};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Checks outgoing request bytes first, then records register writes and new items.
    always @(posedge i_clk) begin : monitor
        t_req_byte want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (req_byte_q.size() == 0) begin
                    $error("unexpected request byte %02h", o_m_tdata);
                    fail_count++;
                end else begin
                    want = req_byte_q.pop_front();
                    if (o_m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, o_m_tdata);
                        fail_count++;
                    end
                    if (o_m_tlast !== want.run_last) begin
                        $error("run_last: expected %0d, actual %0d", want.run_last, o_m_tlast);
                        fail_count++;
                    end
                    if (o_m_tuser !== want.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               want.error_code, o_m_tuser);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_OPCODE:    opcodes.start_opcode    = i_cfg_data;
                    CFG_CONTINUE_OPCODE: opcodes.continue_opcode = i_cfg_data;
                    CFG_OFFSET_OPCODE:   opcodes.offset_opcode   = i_cfg_data;
                    CFG_END_OPCODE:      opcodes.end_opcode      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready)
                build_request('{mode: i_s_tuser, ctrl: i_s_tdata[7:0], data: i_s_tdata[15:8]});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] mode, input logic [7:0] ctrl,
                            input logic [7:0] data);
        item_q.push_back('{mode: mode, ctrl: ctrl, data: data});
    endtask

    task automatic add_frame(input int n_bytes, input bit closed);
        add_item(MODE_BEGIN, 8'($urandom), 8'($urandom));
        repeat (n_bytes) add_item(MODE_DATA, 8'($urandom), 8'($urandom));
        if (closed)
            add_item(MODE_FINISH, 8'($urandom), 8'($urandom));
    endtask

    // Mostly well-formed frames, some left open, the rest loose items of any mode.
    task automatic add_random_items(input int target);
        int made;
        int n_bytes;
        bit closed;
        logic [1:0] mode;
        made = 0;
        while (made < target) begin
            if ($urandom_range(0, 99) < 80) begin
                n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8);
                closed  = ($urandom_range(0, 7) != 0);
                add_frame(n_bytes, closed);
                made += n_bytes + 1 + int'(closed);
            end else begin
                mode = 2'($urandom_range(0, 3));
                add_item(mode, 8'($urandom), 8'($urandom));
                if (mode != MODE_UNUSED)
                    made++;
            end
        end
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_opcodes(input logic [7:0] s, input logic [7:0] c,
                                 input logic [7:0] o, input logic [7:0] e);
        write_reg(CFG_START_OPCODE, s);
        write_reg(CFG_CONTINUE_OPCODE, c);
        write_reg(CFG_OFFSET_OPCODE, o);
        write_reg(CFG_END_OPCODE, e);
    endtask

    // Ignored items produce nothing, so a further wait of DRAIN_CYCLES covers any in flight.
    task automatic wait_drain();
        do @(posedge i_clk);
        while (item_q.size() != 0 || i_s_tvalid || req_byte_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 24;
        recv_idle_pct = 71;

        add_item(MODE_UNUSED, 8'hFF, 8'hFF);
        add_item(MODE_DATA,   8'h00, 8'hFF);
        add_item(MODE_FINISH, 8'hFF, 8'h00);
        add_item(MODE_BEGIN,  8'h00, 8'hFF);
        add_item(MODE_DATA,   8'hFF, 8'h00);
        add_item(MODE_DATA,   8'h00, 8'hFF);
        add_item(MODE_FINISH, 8'h00, 8'h00);
        add_item(MODE_UNUSED, 8'h00, 8'h00);
        add_item(MODE_BEGIN,  8'hFF, 8'h00);
        add_item(MODE_DATA,   8'h00, 8'hFF);
        add_item(MODE_DATA,   8'h00, 8'hFF);
        add_item(MODE_UNUSED, 8'h5A, 8'hA5);
        // A begin inside an open frame abandons it.
        add_item(MODE_BEGIN,  8'hA5, 8'h5A);
        add_item(MODE_DATA,   8'h5A, 8'h01);
        add_item(MODE_FINISH, 8'hFF, 8'hFF);
        add_item(MODE_FINISH, 8'hFF, 8'hFF);
        add_item(MODE_BEGIN,  8'h5A, 8'hFF);
        add_item(MODE_FINISH, 8'h00, 8'h00);
        // One frame runs past the size limit before it is finished.
        add_frame(MAX_FRAME_BYTES + 2, 1'b1);
        add_item(MODE_DATA,   8'h81, 8'h7E);
        wait_drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0:       write_opcodes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                1:       write_opcodes(8'h00, 8'h00, 8'h00, 8'h00);
                5:       write_opcodes(8'h80, 8'h80, 8'h08, 8'h40);
                default: write_opcodes(8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom));
            endcase
            if (seg < 2) begin
                send_idle_pct = 24;
                recv_idle_pct = 71;
            end else if (seg < 4) begin
                send_idle_pct = 71;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            add_random_items(4);
            wait_drain();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- bus_frame_request_builder_core.f -----
hdl/bfrb_pkg.sv
hdl/bfrb_build.sv
hdl/bus_frame_request_builder_core.sv
hdl/bfrb_checker.sv
bench/tb.sv
